@@ design/indexed_min_heap_defines.svh @@
// Assertion macros used by the heap module.
`ifndef INDEXED_MIN_HEAP_DEFINES_SVH
`define INDEXED_MIN_HEAP_DEFINES_SVH

// Asserts that an implication holds at every clock edge outside reset.
`define IMH_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Asserts that a condition leads to another one on the next clock edge.
`define IMH_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/imh_pkg.sv @@
`default_nettype none
package imh_pkg;

    localparam int ELEM_BITS  = 10;
    localparam int KEYF_BITS  = 32;
    localparam int COUNT_BITS = 11;

    localparam logic [1:0] ACT_INSERT   = 2'd0;
    localparam logic [1:0] ACT_DECREASE = 2'd1;
    localparam logic [1:0] ACT_EXTRACT  = 2'd2;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_EMPTY     = 3'd1;
    localparam logic [2:0] ST_ABSENT    = 3'd2;
    localparam logic [2:0] ST_DUP_FULL  = 3'd3;
    localparam logic [2:0] ST_NOT_LOWER = 3'd4;

    typedef struct packed {
        logic [1:0]           action;
        logic [ELEM_BITS-1:0] element_id;
        logic [KEYF_BITS-1:0] new_key;
    } imh_in_t;

    typedef struct packed {
        logic [2:0]            status;
        logic [ELEM_BITS-1:0]  min_element;
        logic [KEYF_BITS-1:0]  min_key;
        logic [COUNT_BITS-1:0] entry_count;
    } imh_out_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LOOKUP,
        S_CHECK,
        S_UP_RD,
        S_UP_CMP,
        S_DN_RD0,
        S_CLEAR,
        S_DN_CMP,
        S_DN_RD2,
        S_DN_RD3,
        S_DN_CMP2,
        S_FIN,
        S_DONE
    } imh_state_t;

endpackage
`default_nettype wire

@@ design/imh_slot_mem.sv @@
`default_nettype none
module imh_slot_mem #(
    parameter int ADDR_BITS = 10,
    parameter int DATA_BITS = 42
) (
    input  wire logic                 clk,
    input  wire logic                 we,
    input  wire logic [ADDR_BITS-1:0] waddr,
    input  wire logic [DATA_BITS-1:0] wdata,
    input  wire logic [ADDR_BITS-1:0] raddr,
    output logic      [DATA_BITS-1:0] rdata
);

    logic [DATA_BITS-1:0] mem [0:(1<<ADDR_BITS)-1];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

@@ design/indexed_min_heap.sv @@
// Channel | Signals                    | Handshake
// input   | start, busy, in_item       | accepted when start and not busy
// result  | done, out_item             | one item per done pulse, no stall
// After accept, insert checks the position table, then reads and compares the
// parent once per level that the entry rises; decrease key first reads its slot.
// Extract reads the root at accept and the last entry next, then sifts down with
// two child reads per level. Rejected items go to done without writing the heap.
// After reset a clearing pass empties all 1024 entries of the position table with
// busy high. The result cannot be stalled; busy is low again after done.
`default_nettype none
module indexed_min_heap #(
    parameter int CAPACITY = 1024,
    parameter int KEY_BITS = 32
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    output logic                  busy,
    input  wire imh_pkg::imh_in_t in_item,
    output logic                  done,
    output imh_pkg::imh_out_t     out_item
);
    import imh_pkg::*;
    `include "indexed_min_heap_defines.svh"

    localparam int SB = (CAPACITY > 2) ? $clog2(CAPACITY) : 1;
    localparam int CB = $clog2(CAPACITY + 1);
    localparam int NE = 1 << ELEM_BITS;
    localparam int DW = ELEM_BITS + KEY_BITS;
    localparam logic [CB-1:0] CAP_C = CB'(CAPACITY);

    imh_state_t state_reg, state_next;

    logic [1:0]          act_reg;
    logic [ELEM_BITS-1:0] elem_reg, elem_next;
    logic [KEY_BITS-1:0] key_reg, key_next;
    logic [CB-1:0]       cnt_reg, cnt_next;
    logic [CB-1:0]       pos_reg, pos_next;
    logic [CB-1:0]       best_reg, best_next;
    logic [KEY_BITS-1:0] bkey_reg, bkey_next;
    logic [ELEM_BITS-1:0] belem_reg, belem_next;
    logic [2:0]          st_reg, st_next;
    logic [ELEM_BITS-1:0] oel_reg, oel_next;
    logic [KEY_BITS-1:0] oky_reg, oky_next;
    logic [ELEM_BITS-1:0] clr_reg, clr_next;

    logic                we;
    logic [SB-1:0]       waddr, raddr;
    logic [DW-1:0]       wdata, rdata;
    logic [ELEM_BITS-1:0] rd_elem;
    logic [KEY_BITS-1:0] rd_key;

    // Each entry holds a presence flag above the heap slot of the element.
    logic [SB:0]         eslot [0:NE-1];
    logic                es_we;
    logic [ELEM_BITS-1:0] es_waddr;
    logic [SB:0]         es_wdata;
    logic [SB:0]         es_rdata;

    logic [CB-1:0]       parent;
    logic [CB:0]         left, right;

    imh_slot_mem #(.ADDR_BITS(SB), .DATA_BITS(DW)) u_mem (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
        .raddr(raddr), .rdata(rdata)
    );

    assign rd_elem = rdata[DW-1:KEY_BITS];
    assign rd_key  = rdata[KEY_BITS-1:0];
    assign parent  = (pos_reg - CB'(1)) >> 1;
    assign left    = {pos_reg, 1'b1};
    assign right   = left + (CB+1)'(1);

    always_ff @(posedge clk)
    begin
        if (es_we)
        begin
            eslot[es_waddr] <= es_wdata;
        end
        es_rdata <= eslot[in_item.element_id];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            cnt_reg   <= '0;
            clr_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            clr_reg   <= clr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && start)
        begin
            act_reg <= in_item.action;
        end
        elem_reg  <= elem_next;
        key_reg   <= key_next;
        pos_reg   <= pos_next;
        best_reg  <= best_next;
        bkey_reg  <= bkey_next;
        belem_reg <= belem_next;
        st_reg    <= st_next;
        oel_reg   <= oel_next;
        oky_reg   <= oky_next;
    end

    // Next state and datapath control.
    always_comb
    begin
        state_next = state_reg;
        elem_next  = elem_reg;
        key_next   = key_reg;
        cnt_next   = cnt_reg;
        pos_next   = pos_reg;
        best_next  = best_reg;
        bkey_next  = bkey_reg;
        belem_next = belem_reg;
        st_next    = st_reg;
        oel_next   = oel_reg;
        oky_next   = oky_reg;
        clr_next   = clr_reg;
        we         = 1'b0;
        waddr      = pos_reg[SB-1:0];
        wdata      = {elem_reg, key_reg};
        raddr      = pos_reg[SB-1:0];
        es_we      = 1'b0;
        es_waddr   = elem_reg;
        es_wdata   = {1'b1, pos_reg[SB-1:0]};
        unique case (state_reg)
            S_CLEAR:
            begin
                es_we    = 1'b1;
                es_waddr = clr_reg;
                es_wdata = '0;
                clr_next = clr_reg + ELEM_BITS'(1);
                if (clr_reg == '1)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    elem_next  = in_item.element_id;
                    key_next   = KEY_BITS'(in_item.new_key);
                    st_next    = ST_OK;
                    oel_next   = '0;
                    oky_next   = '0;
                    raddr      = '0;
                    priority case (in_item.action)
                        ACT_INSERT:
                        begin
                            if (cnt_reg >= CAP_C)
                            begin
                                st_next    = ST_DUP_FULL;
                                state_next = S_DONE;
                            end
                            else
                            begin
                                state_next = S_LOOKUP;
                            end
                        end
                        ACT_DECREASE:
                        begin
                            state_next = S_LOOKUP;
                        end
                        ACT_EXTRACT:
                        begin
                            if (cnt_reg == '0)
                            begin
                                st_next    = ST_EMPTY;
                                state_next = S_DONE;
                            end
                            else
                            begin
                                state_next = S_LOOKUP;
                            end
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_LOOKUP:
            begin
                if (act_reg == ACT_INSERT)
                begin
                    if (es_rdata[SB])
                    begin
                        st_next    = ST_DUP_FULL;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        pos_next   = cnt_reg;
                        cnt_next   = cnt_reg + CB'(1);
                        state_next = S_UP_RD;
                    end
                end
                else if (act_reg == ACT_DECREASE)
                begin
                    if (!es_rdata[SB])
                    begin
                        st_next    = ST_ABSENT;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        pos_next   = CB'(es_rdata[SB-1:0]);
                        raddr      = es_rdata[SB-1:0];
                        state_next = S_CHECK;
                    end
                end
                else
                begin
                    raddr      = SB'(cnt_reg - CB'(1));
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (act_reg == ACT_DECREASE)
                begin
                    if (pos_reg >= cnt_reg)
                    begin
                        st_next    = ST_ABSENT;
                        state_next = S_DONE;
                    end
                    else if (!(key_reg < rd_key))
                    begin
                        st_next    = ST_NOT_LOWER;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_UP_RD;
                    end
                end
                else
                begin
                    // Root was read at accept time; the last entry arrives now.
                    oel_next   = belem_reg;
                    oky_next   = bkey_reg;
                    es_we      = 1'b1;
                    es_waddr   = belem_reg;
                    es_wdata   = '0;
                    elem_next  = rd_elem;
                    key_next   = rd_key;
                    cnt_next   = cnt_reg - CB'(1);
                    pos_next   = '0;
                    state_next = (cnt_reg == CB'(1)) ? S_DONE : S_DN_RD0;
                end
            end
            S_UP_RD:
            begin
                if (pos_reg == '0)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    raddr      = parent[SB-1:0];
                    state_next = S_UP_CMP;
                end
            end
            S_UP_CMP:
            begin
                if (key_reg < rd_key)
                begin
                    we         = 1'b1;
                    wdata      = rdata;
                    es_we      = 1'b1;
                    es_waddr   = rd_elem;
                    pos_next   = parent;
                    state_next = S_UP_RD;
                end
                else
                begin
                    state_next = S_FIN;
                end
            end
            S_DN_RD0:
            begin
                best_next  = pos_reg;
                bkey_next  = key_reg;
                belem_next = elem_reg;
                if (left < {1'b0, cnt_reg})
                begin
                    raddr      = left[SB-1:0];
                    state_next = S_DN_CMP;
                end
                else
                begin
                    state_next = S_FIN;
                end
            end
            S_DN_CMP:
            begin
                if (rd_key < bkey_reg)
                begin
                    best_next  = left[CB-1:0];
                    bkey_next  = rd_key;
                    belem_next = rd_elem;
                end
                state_next = S_DN_RD2;
            end
            S_DN_RD2:
            begin
                if (right < {1'b0, cnt_reg})
                begin
                    raddr      = right[SB-1:0];
                    state_next = S_DN_CMP2;
                end
                else
                begin
                    state_next = S_DN_RD3;
                end
            end
            S_DN_CMP2:
            begin
                if (rd_key < bkey_reg)
                begin
                    best_next  = right[CB-1:0];
                    bkey_next  = rd_key;
                    belem_next = rd_elem;
                end
                state_next = S_DN_RD3;
            end
            S_DN_RD3:
            begin
                if (best_reg == pos_reg)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    we         = 1'b1;
                    wdata      = {belem_reg, bkey_reg};
                    es_we      = 1'b1;
                    es_waddr   = belem_reg;
                    pos_next   = best_reg;
                    state_next = S_DN_RD0;
                end
            end
            S_FIN:
            begin
                we         = 1'b1;
                es_we      = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        // Capture the root on the cycle after accept for extract.
        if (state_reg == S_LOOKUP && act_reg == ACT_EXTRACT)
        begin
            belem_next = rd_elem;
            bkey_next  = rd_key;
        end
    end

    // Outputs.
    always_comb
    begin
        busy                 = (state_reg != S_IDLE);
        done                 = (state_reg == S_DONE);
        out_item.status      = st_reg;
        out_item.min_element = oel_reg;
        out_item.min_key     = KEYF_BITS'(oky_reg);
        out_item.entry_count = COUNT_BITS'(cnt_reg);
    end

    `IMH_ASSERT_IMPL(a_count_bound, clk, rst_n, 1'b1, cnt_reg <= CAP_C, "count overflow")
    `IMH_ASSERT_NEXT(a_done_idle, clk, rst_n, done, !busy, "busy after done")
    `IMH_ASSERT_IMPL(a_no_write_idle, clk, rst_n, state_reg == S_IDLE, !we, "write while idle")
    `IMH_ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy, "accept not taken")

endmodule
`default_nettype wire
